// ----- design/itt_pkg.sv -----
`default_nettype none
package itt_pkg;

    localparam int NUM_CHANNELS_DEF = 3;
    localparam int CH_SLOTS         = 3;
    localparam int CH_GATED         = 2;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [2:0] PORT_CMD  = 3'd3;
    localparam logic [2:0] PORT_CTRL = 3'd4;

    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_LOW   = 2'd1;
    localparam logic [1:0] ACC_HIGH  = 2'd2;
    localparam logic [1:0] ACC_BOTH  = 2'd3;

    localparam logic [2:0] MODE_TERM = 3'd0;
    localparam logic [2:0] MODE_RATE = 3'd2;

    localparam int CTRL_GATE2_BIT   = 0;
    localparam int CTRL_SPEAKER_BIT = 1;
    localparam int CTRL_OUT1_BIT    = 4;
    localparam int CTRL_OUT2_BIT    = 5;

    typedef struct packed {
        logic       tick;
        logic       rd;
        logic       wr;
        logic       cmd;
        logic       ctl;
        logic       gate;
        logic       gate_rise;
        logic [7:0] data;
    } t_chan_req;

endpackage
`default_nettype wire

// ----- design/itt_if.sv -----
`default_nettype none
interface itt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [2:0] port_sel;
    logic [7:0] wdata;

    modport source (output valid, output op, output port_sel, output wdata, input ready);
    modport sink   (input valid, input op, input port_sel, input wdata, output ready);
endinterface

interface itt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] rdata;
    logic       out_zero;
    logic       out_two;

    modport source (output valid, output rdata, output out_zero, output out_two, input ready);
    modport sink   (input valid, input rdata, input out_zero, input out_two, output ready);
endinterface
`default_nettype wire

// ----- design/itt_chan.sv -----
`default_nettype none
module itt_chan (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire itt_pkg::t_chan_req i_req,
    output logic [7:0]             o_rdata,
    output logic                   o_out,
    output logic                   o_out_next
);
    import itt_pkg::*;

    logic [15:0] r_reload, n_reload;
    logic [15:0] r_live, n_live;
    logic [15:0] r_held, n_held;
    logic        r_held_valid, n_held_valid;
    logic        r_rd_high, n_rd_high;
    logic        r_wr_high, n_wr_high;
    logic [7:0]  r_low_byte, n_low_byte;
    logic [2:0]  r_mode, n_mode;
    logic [1:0]  r_access, n_access;
    logic        r_out, n_out;
    logic        r_armed, n_armed;

    logic [15:0] w_dec;
    logic [15:0] w_rd_val;
    logic        w_load;
    logic [15:0] w_load_val;

    assign w_dec    = r_live - 16'd1;
    assign w_rd_val = r_held_valid ? r_held : r_live;

    always_comb begin
        n_reload     = r_reload;
        n_live       = r_live;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_rd_high    = r_rd_high;
        n_wr_high    = r_wr_high;
        n_low_byte   = r_low_byte;
        n_mode       = r_mode;
        n_access     = r_access;
        n_out        = r_out;
        n_armed      = r_armed;
        o_rdata      = 8'h00;
        w_load       = 1'b0;
        w_load_val   = 16'h0000;

        if (i_req.tick) begin
            if (!i_req.gate) begin
                if (r_mode == MODE_RATE) begin
                    n_out = 1'b1;
                end
            end else if (r_armed) begin
                n_live = w_dec;
                if (r_mode == MODE_RATE) begin
                    if (w_dec == 16'd1) begin
                        n_out = 1'b0;
                    end else if (w_dec == 16'd0) begin
                        n_out  = 1'b1;
                        n_live = r_reload;
                    end
                end else if (w_dec == 16'd0) begin
                    n_out = 1'b1;
                end
            end
        end

        if (i_req.ctl) begin
            if (i_req.gate_rise && r_armed && r_mode == MODE_RATE) begin
                n_live = r_reload;
            end
            if (!i_req.gate && r_mode == MODE_RATE) begin
                n_out = 1'b1;
            end
        end

        if (i_req.cmd) begin
            if (i_req.data[5:4] == ACC_LATCH) begin
                if (!r_held_valid) begin
                    n_held       = r_live;
                    n_held_valid = 1'b1;
                end
            end else begin
                n_access     = i_req.data[5:4];
                n_mode       = i_req.data[3:1];
                n_held_valid = 1'b0;
                n_rd_high    = 1'b0;
                n_wr_high    = 1'b0;
                n_armed      = 1'b0;
                n_out        = (i_req.data[3:1] == MODE_RATE);
            end
        end

        if (i_req.wr) begin
            case (r_access)
                ACC_LOW: begin
                    w_load     = 1'b1;
                    w_load_val = {8'h00, i_req.data};
                end
                ACC_HIGH: begin
                    w_load     = 1'b1;
                    w_load_val = {i_req.data, 8'h00};
                end
                default: begin
                    if (!r_wr_high) begin
                        n_low_byte = i_req.data;
                        n_wr_high  = 1'b1;
                        if (r_mode != MODE_RATE) begin
                            n_armed = 1'b0;
                            n_out   = 1'b0;
                        end
                    end else begin
                        n_wr_high  = 1'b0;
                        w_load     = 1'b1;
                        w_load_val = {i_req.data, r_low_byte};
                    end
                end
            endcase
            if (w_load) begin
                n_reload = w_load_val;
                n_live   = w_load_val;
                n_armed  = 1'b1;
                n_out    = (r_mode == MODE_RATE);
            end
        end

        if (i_req.rd) begin
            case (r_access)
                ACC_LOW: begin
                    o_rdata      = w_rd_val[7:0];
                    n_held_valid = 1'b0;
                end
                ACC_HIGH: begin
                    o_rdata      = w_rd_val[15:8];
                    n_held_valid = 1'b0;
                end
                default: begin
                    if (!r_rd_high) begin
                        o_rdata   = w_rd_val[7:0];
                        n_rd_high = 1'b1;
                    end else begin
                        o_rdata      = w_rd_val[15:8];
                        n_rd_high    = 1'b0;
                        n_held_valid = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload     <= 16'h0000;
            r_live       <= 16'h0000;
            r_held       <= 16'h0000;
            r_held_valid <= 1'b0;
            r_rd_high    <= 1'b0;
            r_wr_high    <= 1'b0;
            r_low_byte   <= 8'h00;
            r_mode       <= MODE_TERM;
            r_access     <= ACC_BOTH;
            r_out        <= 1'b0;
            r_armed      <= 1'b0;
        end else begin
            r_reload     <= n_reload;
            r_live       <= n_live;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_rd_high    <= n_rd_high;
            r_wr_high    <= n_wr_high;
            r_low_byte   <= n_low_byte;
            r_mode       <= n_mode;
            r_access     <= n_access;
            r_out        <= n_out;
            r_armed      <= n_armed;
        end
    end

    assign o_out      = r_out;
    assign o_out_next = n_out;

endmodule
`default_nettype wire

// ----- design/interval_timer_three_channel_top.sv -----
// Channel  Dir  Payload                       Beat when
// i_in     in   op, port_sel, wdata           valid && ready
// o_out    out  rdata, out_zero, out_two      valid && ready
//
// One beat in per cycle while the output is not stalled; each result is offered once
// its beat has passed the input register, then the result register, and leaves
// when the output beat is taken.
// Channel counters update in the cycle the beat leaves the input register.
// Reset is synchronous, active low; the input is ready as soon as reset is released.
// A stalled output holds one result and one more beat in the input register.
`default_nettype none
module interval_timer_three_channel_top #(
    parameter int NUM_CHANNELS = itt_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    itt_in_if.sink    i_in,
    itt_out_if.source o_out
);
    import itt_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_in_op;
    logic [2:0] r_in_port;
    logic [7:0] r_in_wdata;

    logic       r_out_valid;
    logic [7:0] r_res_rdata;
    logic       r_res_out0;
    logic       r_res_out2;

    logic       r_gate_two;
    logic       r_speaker;

    logic       w_adv;
    logic       w_fire;
    logic       w_rd;
    logic       w_wr;
    logic       w_tick;
    logic       w_ctl_wr;
    logic       w_new_gate;
    logic       w_gate_rise;

    t_chan_req                  w_req [NUM_CHANNELS];
    logic [7:0]                 w_ch_rdata [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]    w_out;
    logic [NUM_CHANNELS-1:0]    w_out_next;
    logic [CH_SLOTS-1:0]        w_out_pad;
    logic [CH_SLOTS-1:0]        w_out_next_pad;
    logic [7:0]                 w_rdata;

    assign w_adv       = !r_out_valid || o_out.ready;
    assign w_fire      = r_in_valid && w_adv;
    assign i_in.ready  = !r_in_valid || w_adv;

    assign w_rd        = w_fire && (r_in_op == OP_READ);
    assign w_wr        = w_fire && (r_in_op == OP_WRITE);
    assign w_tick      = w_fire && (r_in_op == OP_TICK);
    assign w_ctl_wr    = w_wr && (r_in_port == PORT_CTRL);
    assign w_new_gate  = r_in_wdata[CTRL_GATE2_BIT];
    assign w_gate_rise = w_new_gate && !r_gate_two;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CHANNELS; gi++) begin : g_chan
            assign w_req[gi].tick      = w_tick;
            assign w_req[gi].rd        = w_rd && (r_in_port == 3'(gi));
            assign w_req[gi].wr        = w_wr && (r_in_port == 3'(gi));
            assign w_req[gi].cmd       = w_wr && (r_in_port == PORT_CMD)
                                         && (r_in_wdata[7:6] == 2'(gi));
            assign w_req[gi].ctl       = (gi == CH_GATED) && w_ctl_wr;
            assign w_req[gi].gate      = (gi == CH_GATED) ?
                                         (w_ctl_wr ? w_new_gate : r_gate_two) : 1'b1;
            assign w_req[gi].gate_rise = (gi == CH_GATED) && w_gate_rise;
            assign w_req[gi].data      = r_in_wdata;

            itt_chan u_chan (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_req      (w_req[gi]),
                .o_rdata    (w_ch_rdata[gi]),
                .o_out      (w_out[gi]),
                .o_out_next (w_out_next[gi])
            );
        end
    endgenerate

    assign w_out_pad      = CH_SLOTS'(w_out);
    assign w_out_next_pad = CH_SLOTS'(w_out_next);

    always_comb begin
        w_rdata = 8'h00;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            w_rdata = w_rdata | w_ch_rdata[k];
        end
        if (w_rd && r_in_port == PORT_CTRL) begin
            w_rdata[CTRL_GATE2_BIT]   = r_gate_two;
            w_rdata[CTRL_SPEAKER_BIT] = r_speaker;
            w_rdata[CTRL_OUT1_BIT]    = w_out_pad[1];
            w_rdata[CTRL_OUT2_BIT]    = w_out_pad[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op    <= i_in.op;
            r_in_port  <= i_in.port_sel;
            r_in_wdata <= i_in.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res_rdata <= w_rdata;
            r_res_out0  <= w_out_next_pad[0];
            r_res_out2  <= w_out_next_pad[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_two <= 1'b0;
            r_speaker  <= 1'b0;
        end else if (w_ctl_wr) begin
            r_gate_two <= w_new_gate;
            r_speaker  <= r_in_wdata[CTRL_SPEAKER_BIT];
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.rdata    = r_res_rdata;
    assign o_out.out_zero = r_res_out0;
    assign o_out.out_two  = r_res_out2;

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed beat produced no result");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled while result register empty");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_op != OP_READ) |=> (o_out.rdata == 8'h00))
        else $error("nonzero rdata on a non-read beat");

endmodule
`default_nettype wire
